@@ sv/fsr_pkg.sv @@
`default_nettype none
package fsr_pkg;

	localparam int ITEM_BITS_DEF = 32;

	typedef struct packed {
		logic signed [31:0] frac_num;
		logic [30:0]        frac_den;
		logic               last_item;
	} in_beat_t;

	typedef struct packed {
		logic signed [63:0] whole_part;
		logic signed [63:0] rem_num;
		logic [62:0]        rem_den;
		logic               overflow;
	} out_beat_t;

	typedef struct packed {
		logic [63:0] quo;
		logic [63:0] rem;
	} div_res_t;

endpackage
`default_nettype wire

@@ sv/fsr_div.sv @@
`default_nettype none
module fsr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output fsr_pkg::div_res_t res
);
	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] shifted;
	logic [64:0] diff;

	// restoring divider, one quotient bit per cycle
	assign shifted = {r_q, q_q[63]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[64]) begin
				r_q <= diff[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= shifted[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign res.quo = q_q;
	assign res.rem = r_q;
endmodule
`default_nettype wire

@@ sv/fsr_mul.sv @@
`default_nettype none
module fsr_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      prod,
	output logic             ovf
);
	// 16x16 partial products, four digits of b against four of a
	logic [127:0] acc_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [3:0]   cnt_q;
	logic         busy_q;
	logic [1:0]   ia;
	logic [1:0]   ib;
	logic [31:0]  pp_s1;
	logic [6:0]   sh_s1;
	logic         v_s1;
	logic         last_s1;
	logic [127:0] pp_ext;

	assign ia = cnt_q[1:0];
	assign ib = cnt_q[3:2];
	assign pp_ext = {96'd0, pp_s1} << sh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done    <= 1'b0;
		end else begin
			done    <= v_s1 && last_s1;
			v_s1    <= busy_q;
			last_s1 <= busy_q && (cnt_q == 4'hF);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'hF) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (busy_q) begin
				pp_s1 <= a_q[16*ia +: 16] * b_q[16*ib +: 16];
				sh_s1 <= {({1'b0, ia} + {1'b0, ib}), 4'd0};
			end
			if (v_s1) acc_q <= acc_q + pp_ext;
		end
	end

	assign prod = acc_q[63:0];
	assign ovf  = |acc_q[127:64];
endmodule
`default_nettype wire

@@ sv/fraction_sum_reducer.sv @@
`default_nettype none
// Running sum of signed fractions, held reduced (sign on the numerator).
// The work per input beat is data dependent: every Euclid step and every
// division runs on one shared restoring divider, and products on a 16x16
// multiplier; the Euclid loops set the spread.
// in_ready is low while an item is in work. An item marked last_item
// yields one out beat (mixed number when the sum is at least one) and
// clears the sum; overflow reports any item dropped for exceeding 64 bits.
module fraction_sum_reducer #(
	parameter int ITEM_BITS = fsr_pkg::ITEM_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire fsr_pkg::in_beat_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fsr_pkg::out_beat_t     out_data
);
	localparam logic [4:0] S_IDLE = 5'd0, S_G1 = 5'd1, S_G1W = 5'd2, S_DA = 5'd3,
		S_DAW = 5'd4, S_DB = 5'd5, S_DBW = 5'd6, S_CK = 5'd7, S_CKW = 5'd8,
		S_M1 = 5'd9, S_M1W = 5'd10, S_M2 = 5'd11, S_M2W = 5'd12, S_M3 = 5'd13,
		S_M3W = 5'd14, S_SUM = 5'd15, S_G2 = 5'd16, S_G2W = 5'd17, S_RN = 5'd18,
		S_RNW = 5'd19, S_RD = 5'd20, S_RDW = 5'd21, S_FIN = 5'd22, S_FW = 5'd23,
		S_FG = 5'd24, S_FGW = 5'd25, S_FN = 5'd26, S_FNW = 5'd27, S_FD = 5'd28,
		S_FDW = 5'd29, S_OUT = 5'd30;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [4:0]  st_q;
	logic [4:0]  ret_q;
	logic [63:0] acc_num_q;
	logic [63:0] acc_den_q;
	logic        acc_ovf_q;
	logic        xneg_q;
	logic [63:0] xmag_q;
	logic [63:0] den_q;
	logic        last_q;
	logic [63:0] ga_q;
	logic [63:0] gb_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] ndn_q;
	logic [63:0] t1_q;
	logic [63:0] t2_q;
	logic [63:0] smag_q;
	logic        sneg_q;
	logic [63:0] fnum_q;
	logic        fneg_q;
	fsr_pkg::out_beat_t res_q;

	logic        d_start;
	logic [63:0] d_n;
	logic [63:0] d_d;
	logic        d_done;
	fsr_pkg::div_res_t d_res;
	logic        m_start;
	logic [63:0] m_a;
	logic [63:0] m_b;
	logic        m_done;
	logic [63:0] m_prod;
	logic        m_ovf;

	logic [ITEM_BITS-1:0]   raw;
	logic [ITEM_BITS-1:0]   rawneg;
	logic [ITEM_BITS-2:0]   rawden;
	logic                   acc_neg;
	logic [63:0]            acc_mag;
	logic [64:0]            ssum;

	assign raw     = in_data.frac_num[ITEM_BITS-1:0];
	assign rawneg  = -raw;
	assign rawden  = in_data.frac_den[ITEM_BITS-2:0];
	assign acc_neg = acc_num_q[63];
	assign acc_mag = acc_neg ? -acc_num_q : acc_num_q;
	assign ssum    = {1'b0, t1_q} + {1'b0, t2_q};

	fsr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .dividend(d_n),
		.divisor(d_d), .done(d_done), .res(d_res)
	);

	fsr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start), .a(m_a), .b(m_b),
		.done(m_done), .prod(m_prod), .ovf(m_ovf)
	);

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_data  = res_q;

	always_comb begin
		d_start = 1'b0;
		d_n     = ga_q;
		d_d     = gb_q;
		m_start = 1'b0;
		m_a     = a_q;
		m_b     = den_q;
		unique case (st_q) inside
			S_G1, S_G2, S_FG: d_start = 1'b1;
			S_DA: begin
				d_start = 1'b1;
				d_n     = acc_den_q;
			end
			S_DB: begin
				d_start = 1'b1;
				d_n     = den_q;
			end
			S_CK: begin
				d_start = 1'b1;
				d_n     = POS_MAX;
				d_d     = den_q;
			end
			S_RN: begin
				d_start = 1'b1;
				d_n     = smag_q;
			end
			S_RD: begin
				d_start = 1'b1;
				d_n     = ndn_q;
			end
			S_FIN: begin
				d_start = 1'b1;
				d_n     = acc_mag;
				d_d     = acc_den_q;
			end
			S_FN: begin
				d_start = 1'b1;
				d_n     = fnum_q;
			end
			S_FD: begin
				d_start = 1'b1;
				d_n     = acc_den_q;
			end
			S_M1: m_start = 1'b1;
			S_M2: begin
				m_start = 1'b1;
				m_a     = acc_mag;
				m_b     = b_q;
			end
			S_M3: begin
				m_start = 1'b1;
				m_a     = xmag_q;
				m_b     = a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ret_q     <= S_IDLE;
			acc_num_q <= '0;
			acc_den_q <= 64'd1;
			acc_ovf_q <= 1'b0;
		end else begin
			unique case (st_q) inside
				S_IDLE: if (in_valid) begin
					st_q  <= S_G1;
					ga_q  <= acc_den_q;
					gb_q  <= {33'd0, (rawden == '0) ? 31'd1 :
						31'(rawden)};
					ret_q <= S_DA;
				end
				S_G1, S_G2, S_FG: st_q <= S_G1W;
				S_G1W: if (d_done) begin
					// euclid loop: (a,b) <- (b, a mod b)
					if (d_res.rem == 64'd0) st_q <= ret_q;
					else begin
						ga_q <= gb_q;
						gb_q <= d_res.rem;
						st_q <= S_G1;
					end
				end
				S_DA: st_q <= S_DAW;
				S_DAW: if (d_done) begin
					a_q  <= d_res.quo;
					st_q <= S_DB;
				end
				S_DB: st_q <= S_DBW;
				S_DBW: if (d_done) begin
					b_q  <= d_res.quo;
					st_q <= S_CK;
				end
				S_CK: st_q <= S_CKW;
				S_CKW: if (d_done) begin
					if (a_q > d_res.quo) begin
						acc_ovf_q <= 1'b1;
						st_q      <= last_q ? S_FIN : S_IDLE;
					end else st_q <= S_M1;
				end
				S_M1: st_q <= S_M1W;
				S_M1W: if (m_done) begin
					ndn_q <= m_prod;
					st_q  <= S_M2;
				end
				S_M2: st_q <= S_M2W;
				S_M2W: if (m_done) begin
					t1_q <= m_prod;
					if (m_ovf) begin
						acc_ovf_q <= 1'b1;
						st_q      <= last_q ? S_FIN : S_IDLE;
					end else st_q <= S_M3;
				end
				S_M3: st_q <= S_M3W;
				S_M3W: if (m_done) begin
					t2_q <= m_prod;
					if (m_ovf) begin
						acc_ovf_q <= 1'b1;
						st_q      <= last_q ? S_FIN : S_IDLE;
					end else st_q <= S_SUM;
				end
				S_SUM: begin
					logic [64:0] sm;
					logic        sn;
					sm = '0;
					sn = 1'b0;
					if (acc_neg == xneg_q) begin
						sm = ssum;
						sn = acc_neg;
					end else if (t1_q >= t2_q) begin
						sm = {1'b0, t1_q - t2_q};
						sn = acc_neg;
					end else begin
						sm = {1'b0, t2_q - t1_q};
						sn = xneg_q;
					end
					if (sm == '0) sn = 1'b0;
					if (sm[64] || (sn ? (sm[63:0] > 64'h8000_0000_0000_0000)
						: sm[63])) begin
						acc_ovf_q <= 1'b1;
						st_q      <= last_q ? S_FIN : S_IDLE;
					end else begin
						smag_q <= sm[63:0];
						sneg_q <= sn;
						if (sm == '0) begin
							acc_num_q <= '0;
							acc_den_q <= 64'd1;
							st_q      <= last_q ? S_FIN : S_IDLE;
						end else begin
							ga_q  <= sm[63:0];
							gb_q  <= ndn_q;
							ret_q <= S_RN;
							st_q  <= S_G2;
						end
					end
				end
				S_RN: st_q <= S_RNW;
				S_RNW: if (d_done) begin
					acc_num_q <= sneg_q ? -d_res.quo : d_res.quo;
					st_q      <= S_RD;
				end
				S_RD: st_q <= S_RDW;
				S_RDW: if (d_done) begin
					acc_den_q <= d_res.quo;
					st_q      <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: st_q <= S_FW;
				S_FW: if (d_done) begin
					res_q.overflow <= acc_ovf_q;
					fneg_q <= acc_neg;
					if (!acc_neg && d_res.quo != 64'd0) begin
						res_q.whole_part <= d_res.quo;
						fnum_q <= d_res.rem;
					end else begin
						res_q.whole_part <= '0;
						fnum_q <= acc_mag;
					end
					if ((!acc_neg && d_res.quo != 64'd0 && d_res.rem == 64'd0)
						|| acc_mag == 64'd0) begin
						res_q.rem_num <= '0;
						res_q.rem_den <= 63'd1;
						st_q <= S_OUT;
					end else begin
						ga_q  <= (!acc_neg && d_res.quo != 64'd0) ? d_res.rem
							: acc_mag;
						gb_q  <= acc_den_q;
						ret_q <= S_FN;
						st_q  <= S_FG;
					end
				end
				S_FN: st_q <= S_FNW;
				S_FNW: if (d_done) begin
					res_q.rem_num <= fneg_q ? -d_res.quo : d_res.quo;
					st_q <= S_FD;
				end
				S_FD: st_q <= S_FDW;
				S_FDW: if (d_done) begin
					res_q.rem_den <= d_res.quo[62:0];
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					acc_num_q <= '0;
					acc_den_q <= 64'd1;
					acc_ovf_q <= 1'b0;
					st_q      <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			xneg_q <= raw[ITEM_BITS-1];
			xmag_q <= {{(64-ITEM_BITS){1'b0}}, raw[ITEM_BITS-1] ? rawneg : raw};
			den_q  <= {{(65-ITEM_BITS){1'b0}}, (rawden == '0) ?
				{{(ITEM_BITS-2){1'b0}}, 1'b1} : rawden};
			last_q <= in_data.last_item;
		end
	end

`ifndef ASSERT_OFF
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != 64'd0) else $error("zero denominator");
	a_den_range: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_den_q[63]) else $error("denominator too wide");
	a_out_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> acc_den_q == 64'd1 && !acc_ovf_q)
		else $error("sum not cleared");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready during result");
`endif
endmodule
`default_nettype wire
